// ===== hw/rtl/tile_average_color_assert.svh =====
// assertion macros shared by the rtl
`ifndef TILE_AVERAGE_COLOR_ASSERT_SVH
`define TILE_AVERAGE_COLOR_ASSERT_SVH

// same-cycle implication, off during reset
`define TAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tile_average_color check failed");

// next-cycle implication, off during reset
`define TAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tile_average_color check failed");

`endif

// ===== hw/rtl/tac_pkg.sv =====
package tac_pkg;

    localparam int CH_W       = 8;
    localparam int SUM_W      = 20;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 12;
    localparam int POS_W      = 12;
    localparam int TSIDE_W    = 7;
    localparam int ISIDE_W    = 13;
    localparam int MAX_IMAGE_SIDE = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int DEF_MAX_TILE_COLUMNS = 256;
    localparam int DEF_MAX_TILE_SIDE    = 64;

    localparam logic [TSIDE_W-1:0] RST_TILE_SIDE    = 7'd30;
    localparam logic [ISIDE_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [ISIDE_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TILE_WIDTH   = 2'd0,
        REG_TILE_HEIGHT  = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [TSIDE_W-1:0] tile_width;
        logic [TSIDE_W-1:0] tile_height;
        logic [ISIDE_W-1:0] image_width;
        logic [ISIDE_W-1:0] image_height;
    } t_cfg;

    // one finished tile waiting for its division
    typedef struct packed {
        logic [COL_W-1:0] tile_column;
        logic [ROW_W-1:0] tile_row;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic             frame_done;
    } t_job;

    typedef struct packed {
        logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
        logic                             full;
        logic                             empty;
    } t_q_status;

endpackage

// ===== hw/rtl/tac_if.sv =====
interface tac_pix_if import tac_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            frame_start;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, frame_start, red, green, blue, input ready);
    modport sink   (input valid, frame_start, red, green, blue, output ready);
endinterface

interface tac_tile_if import tac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] tile_column;
    logic [ROW_W-1:0] tile_row;
    logic [CH_W-1:0]  average_red;
    logic [CH_W-1:0]  average_green;
    logic [CH_W-1:0]  average_blue;
    logic             frame_done;

    modport source (output valid, tile_column, tile_row, average_red, average_green,
                    average_blue, frame_done, input ready);
    modport sink   (input valid, tile_column, tile_row, average_red, average_green,
                    average_blue, frame_done, output ready);
endinterface

interface tac_cfg_if import tac_pkg::*; ();
    logic               valid;
    logic               ready;
    t_reg_idx           index;
    logic [ISIDE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tac_front.sv =====
module tac_front import tac_pkg::*; #(
    parameter int MAX_TILE_COLUMNS = DEF_MAX_TILE_COLUMNS,
    parameter int MAX_TILE_SIDE    = DEF_MAX_TILE_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    tac_pix_if.sink                         i_pix,
    input  logic                            i_q_full,
    output logic                            o_push,
    output t_job                            o_job,
    output logic [2*$clog2(MAX_TILE_SIDE+1)-1:0] o_area
);

    localparam int SW  = $clog2(MAX_TILE_SIDE + 1);
    localparam int CCW = $clog2(MAX_TILE_COLUMNS + 1);
    localparam int IW  = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;

    // clamped sizes
    logic [SW-1:0]      c_tw, c_th;
    logic [ISIDE_W-1:0] c_iw, c_ih;

    always_comb begin
        priority if (i_cfg.tile_width == '0) c_tw = SW'(1);
        else if (32'(i_cfg.tile_width) > MAX_TILE_SIDE) c_tw = SW'(MAX_TILE_SIDE);
        else c_tw = SW'(i_cfg.tile_width);
        priority if (i_cfg.tile_height == '0) c_th = SW'(1);
        else if (32'(i_cfg.tile_height) > MAX_TILE_SIDE) c_th = SW'(MAX_TILE_SIDE);
        else c_th = SW'(i_cfg.tile_height);
        priority if (i_cfg.image_width == '0) c_iw = ISIDE_W'(1);
        else if (32'(i_cfg.image_width) > MAX_IMAGE_SIDE) c_iw = ISIDE_W'(MAX_IMAGE_SIDE);
        else c_iw = i_cfg.image_width;
        priority if (i_cfg.image_height == '0) c_ih = ISIDE_W'(1);
        else if (32'(i_cfg.image_height) > MAX_IMAGE_SIDE) c_ih = ISIDE_W'(MAX_IMAGE_SIDE);
        else c_ih = i_cfg.image_height;
    end

    assign o_area = (2*SW)'(c_tw) * (2*SW)'(c_th);

    // raster position
    logic [POS_W-1:0] r_col_pos, r_row_pos, n_col_pos, n_row_pos;
    logic [SW-1:0]    r_off_x, r_off_y, n_off_x, n_off_y;
    logic [CCW-1:0]   r_tcol, n_tcol;
    logic [ROW_W-1:0] r_trow, n_trow;

    logic [POS_W-1:0] c_col, c_row;
    logic [SW-1:0]    c_ox, c_oy;
    logic [CCW-1:0]   c_tcol;
    logic [ROW_W-1:0] c_trow;
    logic             row_end, frame_end, last_x, last_y, col_ok, first, accept;

    // registers for the accumulate cycle
    logic                 r_p1_valid;
    logic [IW-1:0]        r_p1_addr;
    logic                 r_p1_ok, r_p1_first, r_p1_emit, r_p1_fend;
    logic [COL_W-1:0]     r_p1_col;
    logic [ROW_W-1:0]     r_p1_row;
    logic [3*CH_W-1:0]    r_p1_px;
    logic [3*SUM_W-1:0]   r_rd;
    logic [3*SUM_W-1:0]   mem [MAX_TILE_COLUMNS];
    logic [3*SUM_W-1:0]   c_sum;

    assign i_pix.ready = !r_p1_valid && !i_q_full;
    assign accept      = i_pix.valid && i_pix.ready;

    // classify the pixel
    always_comb begin
        c_col  = i_pix.frame_start ? '0 : r_col_pos;
        c_row  = i_pix.frame_start ? '0 : r_row_pos;
        c_ox   = i_pix.frame_start ? '0 : r_off_x;
        c_oy   = i_pix.frame_start ? '0 : r_off_y;
        c_tcol = i_pix.frame_start ? '0 : r_tcol;
        c_trow = i_pix.frame_start ? '0 : r_trow;

        row_end   = ({1'b0, c_col} + 13'd1) >= c_iw;
        frame_end = row_end && (({1'b0, c_row} + 13'd1) >= c_ih);
        last_x    = (({1'b0, c_ox} + (SW+1)'(1)) >= {1'b0, c_tw}) || row_end;
        last_y    = (({1'b0, c_oy} + (SW+1)'(1)) >= {1'b0, c_th})
                    || (({1'b0, c_row} + 13'd1) >= c_ih);
        col_ok    = c_tcol < CCW'(MAX_TILE_COLUMNS);
        first     = (c_ox == '0) && (c_oy == '0);

        n_col_pos = c_col + POS_W'(1);
        n_row_pos = c_row;
        n_off_x   = c_ox;
        n_off_y   = c_oy;
        n_tcol    = c_tcol;
        n_trow    = c_trow;
        if (row_end) begin
            n_col_pos = '0;
            n_off_x   = '0;
            n_tcol    = '0;
            if (frame_end) begin
                n_row_pos = '0;
                n_off_y   = '0;
                n_trow    = '0;
            end else begin
                n_row_pos = c_row + POS_W'(1);
                if (({1'b0, c_oy} + (SW+1)'(1)) >= {1'b0, c_th}) begin
                    n_off_y = '0;
                    n_trow  = c_trow + ROW_W'(1);
                end else begin
                    n_off_y = c_oy + SW'(1);
                end
            end
        end else if (({1'b0, c_ox} + (SW+1)'(1)) >= {1'b0, c_tw}) begin
            n_off_x = '0;
            if (col_ok) n_tcol = c_tcol + CCW'(1);
        end else begin
            n_off_x = c_ox + SW'(1);
        end
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_tcol     <= '0;
            r_trow     <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= accept;
            if (accept) begin
                r_col_pos <= n_col_pos;
                r_row_pos <= n_row_pos;
                r_off_x   <= n_off_x;
                r_off_y   <= n_off_y;
                r_tcol    <= n_tcol;
                r_trow    <= n_trow;
            end
        end
    end

    // pixel payload for the accumulate cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_addr  <= IW'(c_tcol);
            r_p1_ok    <= col_ok;
            r_p1_first <= first;
            r_p1_emit  <= last_x && last_y;
            r_p1_fend  <= frame_end;
            r_p1_col   <= COL_W'(c_tcol);
            r_p1_row   <= c_trow;
            r_p1_px    <= {i_pix.red, i_pix.green, i_pix.blue};
        end
    end

    // column sums memory: read on accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= mem[IW'(c_tcol)];
        if (r_p1_valid && r_p1_ok) mem[r_p1_addr] <= c_sum;
    end

    // accumulate, a tile's first pixel starts from zero
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_sum[c*SUM_W +: SUM_W] = (r_p1_first ? '0 : r_rd[c*SUM_W +: SUM_W])
                                      + SUM_W'(r_p1_px[c*CH_W +: CH_W]);
        end
    end

    assign o_push            = r_p1_valid && r_p1_ok && r_p1_emit;
    assign o_job.tile_column = r_p1_col;
    assign o_job.tile_row    = r_p1_row;
    assign o_job.sum_red     = c_sum[2*SUM_W +: SUM_W];
    assign o_job.sum_green   = c_sum[SUM_W +: SUM_W];
    assign o_job.sum_blue    = c_sum[0 +: SUM_W];
    assign o_job.frame_done  = r_p1_fend;

endmodule

// ===== hw/rtl/tac_queue.sv =====
module tac_queue import tac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign do_push = i_push && (r_cnt != CW'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + PW'(1);
            if (do_pop)  r_rd <= r_rd + PW'(1);
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

    assign o_job          = r_mem[r_rd];
    assign o_status.count = r_cnt;
    assign o_status.full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_status.empty = r_cnt == '0;

endmodule

// ===== hw/rtl/tac_back.sv =====
module tac_back import tac_pkg::*; #(
    parameter int MAX_TILE_SIDE = DEF_MAX_TILE_SIDE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [2*$clog2(MAX_TILE_SIDE+1)-1:0] i_area,
    input  logic                                 i_q_empty,
    input  t_job                                 i_job,
    output logic                                 o_pop,
    tac_tile_if.source                           o_tile
);

    localparam int AW = 2 * $clog2(MAX_TILE_SIDE + 1);
    localparam int KW = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [KW-1:0]    r_step;
    logic [SUM_W-1:0] r_q   [3];
    logic [AW:0]      r_rem [3];
    logic [SUM_W-1:0] n_q   [3];
    logic [AW:0]      n_rem [3];
    logic [AW:0]      trial [3];
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_fend, r_out_valid, out_free;

    assign out_free = !r_out_valid || o_tile.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;

    // one restoring division step per channel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_rem[c][AW-1:0], r_q[c][SUM_W-1]};
            if (trial[c] >= {1'b0, i_area}) begin
                n_rem[c] = trial[c] - {1'b0, i_area};
                n_q[c]   = {r_q[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = trial[c];
                n_q[c]   = {r_q[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_DIV;
            S_DIV:  if (r_step == KW'(SUM_W - 1)) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) r_out_valid <= 1'b1;
            else if (o_tile.ready)             r_out_valid <= 1'b0;
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_step   <= '0;
                r_q[0]   <= i_job.sum_red;
                r_q[1]   <= i_job.sum_green;
                r_q[2]   <= i_job.sum_blue;
                r_rem[0] <= '0;
                r_rem[1] <= '0;
                r_rem[2] <= '0;
                r_col    <= i_job.tile_column;
                r_row    <= i_job.tile_row;
                r_fend   <= i_job.frame_done;
            end
            S_DIV: begin
                r_step <= r_step + KW'(1);
                for (int c = 0; c < 3; c++) begin
                    r_q[c]   <= n_q[c];
                    r_rem[c] <= n_rem[c];
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // output register, averages saturate at full scale
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            o_tile.tile_column   <= r_col;
            o_tile.tile_row      <= r_row;
            o_tile.frame_done    <= r_fend;
            o_tile.average_red   <= (r_q[0] > SUM_W'(255)) ? 8'hFF : CH_W'(r_q[0]);
            o_tile.average_green <= (r_q[1] > SUM_W'(255)) ? 8'hFF : CH_W'(r_q[1]);
            o_tile.average_blue  <= (r_q[2] > SUM_W'(255)) ? 8'hFF : CH_W'(r_q[2]);
        end
    end

    assign o_tile.valid = r_out_valid;

endmodule

// ===== hw/rtl/tile_average_color.sv =====
// Tile average color: RGB pixels come in raster order, one per transaction, and each
// tile's bottom-right pixel (clipped at the image edge) yields one result with the tile
// indices and each channel sum divided by the full tile area. In the front end a pixel
// goes through a column sum memory read, then an add and write back, and no new pixel
// is taken until that write back is done. Finished tiles wait in a four-entry queue; the
// back end divides all three channels at once, one quotient bit per cycle, and apart
// from its own write back the front end stalls only when that queue fills. Config
// writes are taken at any time and must only happen while the block is idle. Tile
// columns at or beyond MAX_TILE_COLUMNS give no results.
`include "tile_average_color_assert.svh"

module tile_average_color import tac_pkg::*; #(
    parameter int MAX_TILE_COLUMNS = DEF_MAX_TILE_COLUMNS,
    parameter int MAX_TILE_SIDE    = DEF_MAX_TILE_SIDE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tac_cfg_if.sink    i_cfg,
    tac_pix_if.sink    i_pix,
    tac_tile_if.source o_tile
);

    localparam int AW = 2 * $clog2(MAX_TILE_SIDE + 1);

    t_cfg          r_cfg;
    t_job          push_job, head_job;
    t_q_status     q_status;
    logic          push, pop;
    logic [AW-1:0] area;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_width   <= RST_TILE_SIDE;
            r_cfg.tile_height  <= RST_TILE_SIDE;
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TILE_WIDTH:   r_cfg.tile_width   <= TSIDE_W'(i_cfg.data);
                REG_TILE_HEIGHT:  r_cfg.tile_height  <= TSIDE_W'(i_cfg.data);
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    tac_front #(
        .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
        .MAX_TILE_SIDE    (MAX_TILE_SIDE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_pix    (i_pix),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_job    (push_job),
        .o_area   (area)
    );

    tac_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    tac_back #(
        .MAX_TILE_SIDE (MAX_TILE_SIDE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_area    (area),
        .i_q_empty (q_status.empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_tile    (o_tile)
    );

    // checks
    `TAC_ASSERT_NOW(a_no_push_when_full, push, !q_status.full)
    `TAC_ASSERT_NEXT(a_front_two_cycles, i_pix.valid && i_pix.ready, !i_pix.ready)
    `TAC_ASSERT_NOW(a_queue_bounded, 1'b1, q_status.count <= QUEUE_DEPTH)

endmodule

// ===== verif/tile_average_color_tb.sv =====
`timescale 1ns / 1ps

module tile_average_color_tb;
    import tac_pkg::*;

    // pixel waiting to be driven
    typedef struct {
        bit               frame_start;
        bit [CH_W-1:0]    red;
        bit [CH_W-1:0]    green;
        bit [CH_W-1:0]    blue;
    } t_pixel;

    // finished tile as the block should report it
    typedef struct {
        bit [COL_W-1:0]   tile_column;
        bit [ROW_W-1:0]   tile_row;
        bit [CH_W-1:0]    average_red;
        bit [CH_W-1:0]    average_green;
        bit [CH_W-1:0]    average_blue;
        bit               frame_done;
    } t_tile;

    localparam int NUM_COLS  = DEF_MAX_TILE_COLUMNS;
    localparam int MAX_SIDE  = DEF_MAX_TILE_SIDE;
    localparam int PIX_GOAL  = 1450;

    logic i_clk;
    logic i_rst_n;

    tac_cfg_if  cfg ();
    tac_pix_if  pix ();
    tac_tile_if tile ();

    tile_average_color uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (pix),
        .o_tile  (tile)
    );

    t_pixel pixel_q[$];
    t_tile  tile_exp_q[$];
    int     error_count = 0;
    int     pixels_sent = 0;
    int     tiles_seen  = 0;
    int     phase_count = 0;
    bit     pix_taken   = 0;

    // shadow of the block's configuration and raster position
    bit [TSIDE_W-1:0] sh_tile_w, sh_tile_h;
    bit [ISIDE_W-1:0] sh_img_w, sh_img_h;
    bit [SUM_W-1:0]   col_sum [NUM_COLS][3];
    int               pos_x, pos_y, off_x, off_y, tcol, trow;

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    endtask

    function automatic int clamp_side(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the tile accumulation by one pixel, queue a tile if one finishes
    task automatic accumulate_pixel(input t_pixel p);
        int  tw, th, iw, ih, area, q;
        bit  row_end, frame_end, last_x, last_y, first;
        bit [SUM_W-1:0] px[3];
        t_tile t;
        tw = clamp_side(sh_tile_w, MAX_SIDE);
        th = clamp_side(sh_tile_h, MAX_SIDE);
        iw = clamp_side(sh_img_w, MAX_IMAGE_SIDE);
        ih = clamp_side(sh_img_h, MAX_IMAGE_SIDE);
        if (p.frame_start) begin
            pos_x = 0; pos_y = 0; off_x = 0; off_y = 0; tcol = 0; trow = 0;
        end
        px[0] = p.red; px[1] = p.green; px[2] = p.blue;
        row_end   = pos_x + 1 >= iw;
        frame_end = row_end && (pos_y + 1 >= ih);
        last_x    = (off_x + 1 >= tw) || row_end;
        last_y    = (off_y + 1 >= th) || (pos_y + 1 >= ih);
        if (tcol < NUM_COLS) begin
            first = (off_x == 0) && (off_y == 0);
            for (int c = 0; c < 3; c++)
                col_sum[tcol][c] = (first ? '0 : col_sum[tcol][c]) + px[c];
            if (last_x && last_y) begin
                area            = tw * th;
                t.tile_column   = tcol[COL_W-1:0];
                t.tile_row      = trow[ROW_W-1:0];
                q = col_sum[tcol][0] / area; t.average_red   = (q > 255) ? 8'hFF : q[7:0];
                q = col_sum[tcol][1] / area; t.average_green = (q > 255) ? 8'hFF : q[7:0];
                q = col_sum[tcol][2] / area; t.average_blue  = (q > 255) ? 8'hFF : q[7:0];
                t.frame_done    = frame_end;
                tile_exp_q.push_back(t);
            end
        end
        // raster advance
        if (row_end) begin
            pos_x = 0; off_x = 0; tcol = 0;
            if (frame_end) begin
                pos_y = 0; off_y = 0; trow = 0;
            end else begin
                pos_y++;
                if (off_y + 1 >= th) begin
                    off_y = 0;
                    trow  = (trow + 1) & 12'hFFF;
                end else begin
                    off_y++;
                end
            end
        end else begin
            pos_x++;
            if (off_x + 1 >= tw) begin
                off_x = 0;
                if (tcol < NUM_COLS) tcol++;
            end else begin
                off_x++;
            end
        end
    endtask

    // monitor: track config writes, predict accepted pixels, check tiles
    always @(posedge i_clk) begin
        t_tile e;
        pix_taken <= pix.valid && pix.ready;
        if (i_rst_n) begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_TILE_WIDTH:   sh_tile_w <= cfg.data[TSIDE_W-1:0];
                    REG_TILE_HEIGHT:  sh_tile_h <= cfg.data[TSIDE_W-1:0];
                    REG_IMAGE_WIDTH:  sh_img_w  <= cfg.data;
                    REG_IMAGE_HEIGHT: sh_img_h  <= cfg.data;
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                accumulate_pixel('{pix.frame_start, pix.red, pix.green, pix.blue});
                pixels_sent++;
            end
            if (tile.valid && tile.ready) begin
                tiles_seen++;
                if (tile_exp_q.size() == 0) begin
                    report_mismatch("unexpected tile column", tile.tile_column, -1);
                end else begin
                    e = tile_exp_q.pop_front();
                    if (tile.tile_column !== e.tile_column)
                        report_mismatch("tile_column", tile.tile_column, e.tile_column);
                    if (tile.tile_row !== e.tile_row)
                        report_mismatch("tile_row", tile.tile_row, e.tile_row);
                    if (tile.average_red !== e.average_red)
                        report_mismatch("average_red", tile.average_red, e.average_red);
                    if (tile.average_green !== e.average_green)
                        report_mismatch("average_green", tile.average_green, e.average_green);
                    if (tile.average_blue !== e.average_blue)
                        report_mismatch("average_blue", tile.average_blue, e.average_blue);
                    if (tile.frame_done !== e.frame_done)
                        report_mismatch("frame_done", tile.frame_done, e.frame_done);
                end
            end
        end
    end

    // no idling on either side for a stretch in the middle of the run
    function automatic bit stall_now();
        if (pixels_sent >= 600 && pixels_sent < 900) return 1'b0;
        return $urandom_range(0, 99) < 20;
    endfunction

    // pixel driver and result sink
    always @(negedge i_clk) begin
        t_pixel p;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
            tile.ready <= 1'b0;
        end else begin
            tile.ready <= !stall_now();
            if (!pix.valid || pix_taken) begin
                if (pixel_q.size() == 0 || stall_now()) begin
                    pix.valid <= 1'b0;
                end else begin
                    p = pixel_q.pop_front();
                    pix.valid       <= 1'b1;
                    pix.frame_start <= p.frame_start;
                    pix.red         <= p.red;
                    pix.green       <= p.green;
                    pix.blue        <= p.blue;
                end
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[ISIDE_W-1:0];
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // wait for the block to drain, then reconfigure
    task automatic start_phase(input int tw, input int th, input int iw, input int ih);
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || pix.valid || tile_exp_q.size() != 0);
        repeat (60) @(posedge i_clk);
        write_reg(REG_IMAGE_WIDTH, iw);
        write_reg(REG_TILE_HEIGHT, th);
        write_reg(REG_TILE_WIDTH, tw);
        write_reg(REG_IMAGE_HEIGHT, ih);
        phase_count++;
    endtask

    function automatic bit [7:0] channel_value();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_pixels(input int n, input bit restart, input int noise_pct);
        t_pixel p;
        for (int k = 0; k < n; k++) begin
            p.frame_start = (k == 0 && restart) || ($urandom_range(0, 99) < noise_pct);
            p.red   = channel_value();
            p.green = channel_value();
            p.blue  = channel_value();
            pixel_q.push_back(p);
        end
    endtask

    // stimulus
    initial begin
        int tw, th, iw, ih, frame;
        t_pixel p;
        i_rst_n    = 1'b0;
        cfg.valid  = 1'b0;
        cfg.index  = REG_TILE_WIDTH;
        cfg.data   = '0;
        pix.valid  = 1'b0;
        pix.frame_start = 1'b0;
        pix.red    = '0;
        pix.green  = '0;
        pix.blue   = '0;
        tile.ready = 1'b0;
        sh_tile_w  = RST_TILE_SIDE;
        sh_tile_h  = RST_TILE_SIDE;
        sh_img_w   = RST_IMAGE_WIDTH;
        sh_img_h   = RST_IMAGE_HEIGHT;
        pos_x = 0; pos_y = 0; off_x = 0; off_y = 0; tcol = 0; trow = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // partial edge tiles, channel extremes, and running past the frame end
        start_phase(2, 2, 3, 3);
        for (int k = 0; k < 12; k++) begin
            p.frame_start = (k == 0);
            p.red   = (k % 2) ? 8'hFF : 8'h00;
            p.green = (k % 3) ? 8'h00 : 8'hFF;
            p.blue  = 8'hFF;
            pixel_q.push_back(p);
        end
        // clamped sizes: zero and oversize tile, zero image width, stray high bits
        start_phase(13'h1F80, 0, 0, 2);
        queue_pixels(3, 1, 0);
        start_phase(127, 127, 5, 3);
        queue_pixels(15, 1, 0);
        // widest image: columns past capacity are dropped
        start_phase(1, 1, 8191, 1);
        queue_pixels(300, 1, 0);
        // tallest image with the largest tile side
        start_phase(3, 64, 1, 4096);
        queue_pixels(140, 1, 0);
        // larger tiles in a wide image, partial frame only
        start_phase(64, 2, 4096, 3);
        queue_pixels(260, 1, 0);

        // random phases of one to three whole frames and up to four extra pixels, with a little restart noise
        while (pixels_sent + pixel_q.size() < PIX_GOAL) begin
            tw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
            th = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
            iw = $urandom_range(0, 20);
            ih = $urandom_range(0, 12);
            start_phase(tw, th, iw, ih);
            frame = clamp_side(iw, MAX_IMAGE_SIDE) * clamp_side(ih, MAX_IMAGE_SIDE);
            queue_pixels(frame * $urandom_range(1, 3) + $urandom_range(0, 4), 1,
                         ($urandom_range(0, 3) == 0) ? 2 : 0);
        end

        // drain and settle
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || pix.valid || tile_exp_q.size() != 0);
        repeat (100) @(posedge i_clk);
        if (tile_exp_q.size() != 0)
            report_mismatch("tiles still outstanding", 0, tile_exp_q.size());
        $display("ran %0d configurations, %0d pixels in, %0d tiles checked",
                 phase_count, pixels_sent, tiles_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
